// ===== hdl/sir_pkg.sv =====
package sir_pkg;

    localparam int LEN_BITS   = 31;
    localparam int COUNT_BITS = 31;

    localparam logic ST_OK        = 1'b0;
    localparam logic ST_ZERO_STEP = 1'b1;

    localparam int UB_START_GIVEN = 0;
    localparam int UB_STOP_GIVEN  = 1;
    localparam int UB_STEP_GIVEN  = 2;
    localparam int IN_USER_BITS   = 3;

    typedef struct packed {
        logic valid;
        logic ready;
    } t_hs;

endpackage

// ===== hdl/sir_front.sv =====
module sir_front #(
    parameter int INDEX_BITS = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [sir_pkg::LEN_BITS-1:0]       i_seq_length,
    input  logic signed [INDEX_BITS-1:0]       i_slice_start,
    input  logic                               i_start_given,
    input  logic signed [INDEX_BITS-1:0]       i_slice_stop,
    input  logic                               i_stop_given,
    input  logic signed [INDEX_BITS-1:0]       i_slice_step,
    input  logic                               i_step_given,
    output sir_pkg::t_hs                       o_hs_valid,
    input  logic                               i_out_ready,
    output logic [sir_pkg::LEN_BITS+4*INDEX_BITS:0] o_data
);

    localparam int EW = ((INDEX_BITS > 32) ? INDEX_BITS : 32) + 2;
    localparam int PW = sir_pkg::LEN_BITS + 4 * INDEX_BITS + 1;

    logic signed [EW-1:0] n_len;
    logic signed [EW-1:0] n_lo;
    logic signed [EW-1:0] n_hi;
    logic signed [EW-1:0] n_first;
    logic signed [EW-1:0] n_last;
    logic signed [EW-1:0] n_diff;
    logic [INDEX_BITS-1:0] n_step;
    logic [INDEX_BITS-1:0] n_mag;
    logic                  n_neg;
    logic                  n_zero;
    logic [PW-1:0]         n_data;
    logic                  r_valid;
    logic [PW-1:0]         r_data;
    logic                  w_advance;

    function automatic logic signed [EW-1:0] clamp_end(
        input logic signed [INDEX_BITS-1:0] x,
        input logic signed [EW-1:0]         len,
        input logic signed [EW-1:0]         lo,
        input logic signed [EW-1:0]         hi
    );
        logic signed [EW-1:0] v;
        v = {{(EW-INDEX_BITS){x[INDEX_BITS-1]}}, x};
        if (v < 0) begin
            v = v + len;
        end
        if (v < lo) begin
            v = lo;
        end else if (v > hi) begin
            v = hi;
        end
        return v;
    endfunction

    always_comb begin
        n_len  = {{(EW-sir_pkg::LEN_BITS){1'b0}}, i_seq_length};
        n_step = i_step_given ? i_slice_step : INDEX_BITS'(1);
        n_neg  = n_step[INDEX_BITS-1];
        n_zero = (n_step == '0);
        n_mag  = n_neg ? (~n_step + INDEX_BITS'(1)) : n_step;
        n_lo   = n_neg ? -EW'(1) : '0;
        n_hi   = n_neg ? (n_len - EW'(1)) : n_len;
        n_first = n_neg ? (n_len - EW'(1)) : '0;
        n_last  = n_neg ? -EW'(1) : n_len;
        if (i_start_given) begin
            n_first = clamp_end(i_slice_start, n_len, n_lo, n_hi);
        end
        if (i_stop_given) begin
            n_last = clamp_end(i_slice_stop, n_len, n_lo, n_hi);
        end
        n_diff = n_neg ? (n_first - n_last) : (n_last - n_first);
        if (n_diff < 0) begin
            n_diff = '0;
        end
        if (n_zero) begin
            n_data = {{sir_pkg::LEN_BITS{1'b0}}, INDEX_BITS'(1),
                      {(3*INDEX_BITS){1'b0}}, sir_pkg::ST_ZERO_STEP};
        end else begin
            n_data = {n_diff[sir_pkg::LEN_BITS-1:0], n_mag,
                      n_first[INDEX_BITS-1:0], n_last[INDEX_BITS-1:0],
                      n_step, sir_pkg::ST_OK};
        end
    end

    assign w_advance = !r_valid || i_out_ready;
    assign o_ready   = w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_advance) begin
            r_valid <= i_valid;
        end
        if (w_advance && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_hs_valid.valid = r_valid;
    assign o_hs_valid.ready = w_advance;
    assign o_data = r_data;

endmodule

// ===== hdl/sir_queue.sv =====
module sir_queue #(
    parameter int WIDTH = 160
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [WIDTH-1:0] o_data
);

    logic [WIDTH-1:0] r_mem [0:1];
    logic             r_wp;
    logic             r_rp;
    logic [1:0]       r_cnt;
    logic             w_push;
    logic             w_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
        if (w_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

// ===== hdl/sir_back.sv =====
module sir_back #(
    parameter int INDEX_BITS = 32
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_valid,
    output logic                                    o_ready,
    input  logic [sir_pkg::LEN_BITS+4*INDEX_BITS:0] i_data,
    output logic                                    o_valid,
    input  logic                                    i_ready,
    output logic [INDEX_BITS-1:0]                   o_start_index,
    output logic [INDEX_BITS-1:0]                   o_stop_index,
    output logic [INDEX_BITS-1:0]                   o_step_value,
    output logic [sir_pkg::COUNT_BITS-1:0]          o_element_count,
    output logic                                    o_status
);

    localparam int NS = sir_pkg::LEN_BITS;
    localparam int QW = 3 * INDEX_BITS + 1;

    logic                  r_v   [0:NS];
    logic [INDEX_BITS-1:0] r_rem [0:NS];
    logic [NS-1:0]         r_dvd [0:NS];
    logic [NS-1:0]         r_quo [0:NS];
    logic [INDEX_BITS-1:0] r_mag [0:NS];
    logic                  r_zs  [0:NS];
    logic [QW-1:0]         r_pay [0:NS];
    logic [INDEX_BITS-1:0] n_rem [1:NS];
    logic [NS-1:0]         n_quo [1:NS];
    logic [INDEX_BITS:0]   w_trial [1:NS];
    logic                  w_ge    [1:NS];
    logic [NS-1:0]         w_span;
    logic                  w_en;
    logic                  r_ov;
    logic [QW-1:0]         r_opay;
    logic [NS-1:0]         r_ocnt;

    assign w_en    = !r_ov || i_ready;
    assign o_ready = w_en;
    assign w_span  = i_data[QW+INDEX_BITS +: NS];

    always_comb begin
        for (int j = 1; j <= NS; j++) begin
            w_trial[j] = {r_rem[j-1], r_dvd[j-1][NS-1]};
            w_ge[j]    = (w_trial[j] >= {1'b0, r_mag[j-1]});
            n_rem[j]   = w_ge[j] ? INDEX_BITS'(w_trial[j] - {1'b0, r_mag[j-1]})
                                 : w_trial[j][INDEX_BITS-1:0];
            n_quo[j]   = {r_quo[j-1][NS-2:0], w_ge[j]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j <= NS; j++) begin
                r_v[j] <= 1'b0;
            end
            r_ov <= 1'b0;
        end else if (w_en) begin
            r_v[0] <= i_valid;
            for (int j = 1; j <= NS; j++) begin
                r_v[j] <= r_v[j-1];
            end
            r_ov <= r_v[NS];
        end
        if (w_en) begin
            r_rem[0] <= '0;
            r_dvd[0] <= w_span - NS'(1);
            r_quo[0] <= '0;
            r_mag[0] <= i_data[QW +: INDEX_BITS];
            r_zs[0]  <= (w_span == '0);
            r_pay[0] <= i_data[QW-1:0];
            for (int j = 1; j <= NS; j++) begin
                r_rem[j] <= n_rem[j];
                r_dvd[j] <= {r_dvd[j-1][NS-2:0], 1'b0};
                r_quo[j] <= n_quo[j];
                r_mag[j] <= r_mag[j-1];
                r_zs[j]  <= r_zs[j-1];
                r_pay[j] <= r_pay[j-1];
            end
            r_opay <= r_pay[NS];
            r_ocnt <= r_zs[NS] ? '0 : (r_quo[NS] + NS'(1));
        end
    end

    assign o_valid         = r_ov;
    assign o_start_index   = r_opay[2*INDEX_BITS+1 +: INDEX_BITS];
    assign o_stop_index    = r_opay[INDEX_BITS+1 +: INDEX_BITS];
    assign o_step_value    = r_opay[1 +: INDEX_BITS];
    assign o_status        = r_opay[0];
    assign o_element_count = r_ocnt;

endmodule

// ===== hdl/slice_index_resolver.sv =====
// Throughput: one request per cycle while the master side does not hold a result;
// the 31-stage restoring divider that forms the element count takes a new
// dividend in every cycle in which the output is not stalled.
// Reset: i_rst_n is synchronous and active low; it empties the front register,
// the queue and the divider pipeline. No result is pending after reset.
module slice_index_resolver #(
    parameter int INDEX_BITS = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // seq_length, slice_start, slice_stop, slice_step, zero fill
    input  logic [((sir_pkg::LEN_BITS+3*INDEX_BITS+7)/8)*8-1:0] s_axis_tdata,
    // start_given, stop_given, step_given
    input  logic [sir_pkg::IN_USER_BITS-1:0] s_axis_tuser,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // start_index, stop_index, step_value, element_count, zero fill
    output logic [((sir_pkg::COUNT_BITS+3*INDEX_BITS+7)/8)*8-1:0] m_axis_tdata,
    // status
    output logic [0:0]          m_axis_tuser
);

    localparam int PW  = sir_pkg::LEN_BITS + 4 * INDEX_BITS + 1;
    localparam int ODW = ((sir_pkg::COUNT_BITS + 3 * INDEX_BITS + 7) / 8) * 8;
    localparam int L   = sir_pkg::LEN_BITS;

    sir_pkg::t_hs          w_front_hs;
    logic [PW-1:0]         w_front_data;
    logic                  w_q_in_ready;
    logic                  w_q_valid;
    logic [PW-1:0]         w_q_data;
    logic                  w_back_ready;
    logic [INDEX_BITS-1:0] w_start;
    logic [INDEX_BITS-1:0] w_stop;
    logic [INDEX_BITS-1:0] w_step;
    logic [sir_pkg::COUNT_BITS-1:0] w_count;
    logic                  w_status;

    sir_front #(.INDEX_BITS(INDEX_BITS)) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (s_axis_tvalid),
        .o_ready       (s_axis_tready),
        .i_seq_length  (s_axis_tdata[L-1:0]),
        .i_slice_start (s_axis_tdata[L +: INDEX_BITS]),
        .i_start_given (s_axis_tuser[sir_pkg::UB_START_GIVEN]),
        .i_slice_stop  (s_axis_tdata[L+INDEX_BITS +: INDEX_BITS]),
        .i_stop_given  (s_axis_tuser[sir_pkg::UB_STOP_GIVEN]),
        .i_slice_step  (s_axis_tdata[L+2*INDEX_BITS +: INDEX_BITS]),
        .i_step_given  (s_axis_tuser[sir_pkg::UB_STEP_GIVEN]),
        .o_hs_valid    (w_front_hs),
        .i_out_ready   (w_q_in_ready),
        .o_data        (w_front_data)
    );

    sir_queue #(.WIDTH(PW)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_front_hs.valid),
        .o_ready (w_q_in_ready),
        .i_data  (w_front_data),
        .o_valid (w_q_valid),
        .i_ready (w_back_ready),
        .o_data  (w_q_data)
    );

    sir_back #(.INDEX_BITS(INDEX_BITS)) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (w_q_valid),
        .o_ready         (w_back_ready),
        .i_data          (w_q_data),
        .o_valid         (m_axis_tvalid),
        .i_ready         (m_axis_tready),
        .o_start_index   (w_start),
        .o_stop_index    (w_stop),
        .o_step_value    (w_step),
        .o_element_count (w_count),
        .o_status        (w_status)
    );

    assign m_axis_tdata = ODW'({w_count, w_step, w_stop, w_start});
    assign m_axis_tuser = w_status;

endmodule

// ===== hdl/sir_checker.sv =====
module sir_checker #(
    parameter int INDEX_BITS = 32
) (
    input logic i_clk,
    input logic i_rst_n,
    input logic m_axis_tvalid,
    input logic m_axis_tready,
    input logic [((sir_pkg::COUNT_BITS+3*INDEX_BITS+7)/8)*8-1:0] m_axis_tdata,
    input logic [0:0] m_axis_tuser
);

    localparam int OFW = sir_pkg::COUNT_BITS + 3 * INDEX_BITS;

    a_zero_step_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[0] == sir_pkg::ST_ZERO_STEP)
            |-> (m_axis_tdata[OFW-1:0] == '0))
        else $error("zero-step result carries nonzero fields");

    a_ok_step_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[0] == sir_pkg::ST_OK)
            |-> (m_axis_tdata[2*INDEX_BITS +: INDEX_BITS] != '0))
        else $error("ok result with zero step");

    a_no_out_after_reset: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> !m_axis_tvalid)
        else $error("result present right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready)
            |=> (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("stalled result changed");

endmodule

bind slice_index_resolver sir_checker #(.INDEX_BITS(INDEX_BITS)) u_sir_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
